>>> design/rau_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and angle helpers for the rotary angle unwrap tracker.
// No dependencies; used by rau_div and rotary_angle_unwrap_tracker.
package rau_pkg;

  localparam int unsigned ANGLE_W = 12;
  localparam int unsigned POS_W   = 32;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned REV_W   = 20;
  localparam int unsigned DIV_W   = 32;

  localparam logic [19:0] US_PER_S  = 20'd1000000;
  localparam logic signed [13:0] HALF_TURN = 14'sd2048;
  localparam logic signed [13:0] FULL_TURN = 14'sd4096;

  // configuration register indexes
  localparam logic CFG_ANGLE_OFFSET = 1'b0;
  localparam logic CFG_REVERSE      = 1'b1;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [ANGLE_W-1:0] correct_angle(
    input logic [ANGLE_W-1:0] raw,
    input logic [ANGLE_W-1:0] offset,
    input logic               reverse
  );
    logic [ANGLE_W-1:0] a;
    a = raw + offset;
    if (reverse) begin
      a = ANGLE_W'(0) - a;
    end
    return a;
  endfunction

endpackage

>>> design/rau_div.sv
`timescale 1ns / 1ps
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// Depends on rau_pkg for widths and the control/status structs.
module rau_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rau_pkg::div_ctrl_t            ctrl,
  input  logic [rau_pkg::DIV_W-1:0]     dividend,
  input  logic [rau_pkg::DIV_W-1:0]     divisor,
  output rau_pkg::div_stat_t            stat,
  output logic [rau_pkg::DIV_W-1:0]     quotient
);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [4:0]                  cnt_r, cnt_nxt;
  logic [rau_pkg::DIV_W-1:0]   rem_r, rem_nxt;
  logic [rau_pkg::DIV_W-1:0]   quo_r, quo_nxt;
  logic [rau_pkg::DIV_W:0]     shifted;
  logic [rau_pkg::DIV_W+1:0]   diff;
  logic                        fits;

  assign shifted = {rem_r, quo_r[rau_pkg::DIV_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, divisor};
  assign fits    = ~diff[rau_pkg::DIV_W+1];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (ctrl.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      // remainder stays below the divisor, so the low bits hold it
      rem_nxt = fits ? diff[rau_pkg::DIV_W-1:0] : shifted[rau_pkg::DIV_W-1:0];
      quo_nxt = {quo_r[rau_pkg::DIV_W-2:0], fits};
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

>>> design/rotary_angle_unwrap_tracker.sv
`timescale 1ns / 1ps
// Rotary angle unwrap tracker: one beat in, one result beat out, one item at a time.
// Depends on rau_pkg and rau_div.
//
// Each input beat takes a sensor angle and a microsecond timestamp, corrects the angle by
// the configured offset and direction, unwraps it into a 32-bit cumulative position and
// derives a signed speed in counts per second. When a speed is computed, an item goes
// from CALC through MUL, LOAD and DIV (the 32-bit shift-subtract divider runs in DIV and
// reports through its done flag) to DONE; otherwise (preset, failed read, zero elapsed
// time) it goes from CALC straight to DONE, which loads the result register. The next
// beat can be accepted in the cycle after the result is loaded. in_stall stays high
// until the item's result is in the output register; a waiting result does not block
// acceptance of the next beat, only its completion. Configuration writes take effect at
// once and belong between items.
module rotary_angle_unwrap_tracker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic                               cfg_addr,
  input  logic [rau_pkg::ANGLE_W-1:0]        cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_action,
  input  logic [rau_pkg::ANGLE_W-1:0]        in_raw_angle,
  input  logic                               in_read_error,
  input  logic                               in_use_new_reading,
  input  logic [rau_pkg::TIME_W-1:0]         in_time_us,
  input  logic signed [rau_pkg::POS_W-1:0]   in_preset_position,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [rau_pkg::ANGLE_W-1:0]        out_angle,
  output logic signed [rau_pkg::POS_W-1:0]   out_position,
  output logic signed [rau_pkg::REV_W-1:0]   out_revolutions,
  output logic signed [rau_pkg::POS_W-1:0]   out_speed_counts_per_s,
  output logic                               out_speed_valid
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_CALC = 6'b000010,
    ST_MUL  = 6'b000100,
    ST_LOAD = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [rau_pkg::ANGLE_W-1:0] offset_r;
  logic                        reverse_r;

  // captured input beat
  logic                        act_r;
  logic [rau_pkg::ANGLE_W-1:0] raw_r;
  logic                        err_r;
  logic                        use_new_r;
  logic [rau_pkg::TIME_W-1:0]  time_r;
  logic [rau_pkg::POS_W-1:0]   preset_r;

  // tracking state
  logic [rau_pkg::ANGLE_W-1:0] good_angle_r, good_angle_nxt;
  logic [rau_pkg::ANGLE_W-1:0] sref_angle_r, sref_angle_nxt;
  logic [rau_pkg::TIME_W-1:0]  sref_time_r, sref_time_nxt;
  logic [rau_pkg::POS_W-1:0]   cum_pos_r, cum_pos_nxt;
  logic [rau_pkg::ANGLE_W-1:0] uref_angle_r, uref_angle_nxt;

  // per-item working registers
  logic [rau_pkg::ANGLE_W-1:0] res_angle_r, res_angle_nxt;
  logic [rau_pkg::POS_W-1:0]   res_pos_r, res_pos_nxt;
  logic [rau_pkg::POS_W-1:0]   res_speed_r, res_speed_nxt;
  logic                        res_valid_r, res_valid_nxt;
  logic [rau_pkg::ANGLE_W-1:0] mag_r, mag_nxt;
  logic                        neg_r, neg_nxt;
  logic [rau_pkg::TIME_W-1:0]  elapsed_r, elapsed_nxt;
  logic [rau_pkg::DIV_W-1:0]   prod_r;

  // output register
  logic                        out_valid_r;
  logic [rau_pkg::ANGLE_W-1:0] out_angle_r;
  logic [rau_pkg::POS_W-1:0]   out_pos_r;
  logic [rau_pkg::REV_W-1:0]   out_rev_r;
  logic [rau_pkg::POS_W-1:0]   out_speed_r;
  logic                        out_sv_r;

  logic                        in_fire;
  logic                        out_free;
  logic                        out_load;

  // CALC helpers
  logic [rau_pkg::ANGLE_W-1:0] corr;
  logic [rau_pkg::ANGLE_W-1:0] smp_angle;
  logic [rau_pkg::TIME_W-1:0]  elapsed_c;
  logic signed [13:0]          delta_raw;
  logic signed [13:0]          delta;
  logic signed [13:0]          v_s;
  logic signed [13:0]          last_s;
  logic signed [13:0]          step;

  rau_pkg::div_ctrl_t          div_ctrl;
  rau_pkg::div_stat_t          div_stat;
  logic [rau_pkg::DIV_W-1:0]   div_q;

  assign in_fire  = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (state_r == ST_DONE) && out_free;

  assign div_ctrl.start = (state_r == ST_LOAD);

  rau_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (div_ctrl),
    .dividend (prod_r),
    .divisor  (elapsed_r),
    .stat     (div_stat),
    .quotient (div_q)
  );

  assign corr      = rau_pkg::correct_angle(raw_r, offset_r, reverse_r);
  assign smp_angle = use_new_r ? corr : good_angle_r;
  assign elapsed_c = time_r - sref_time_r;
  assign delta_raw = $signed({2'b00, smp_angle}) - $signed({2'b00, sref_angle_r});
  assign v_s       = $signed({2'b00, smp_angle});
  assign last_s    = $signed({2'b00, uref_angle_r});

  always_comb begin
    if (delta_raw > rau_pkg::HALF_TURN) begin
      delta = delta_raw - rau_pkg::FULL_TURN;
    end else if (delta_raw < -rau_pkg::HALF_TURN) begin
      delta = delta_raw + rau_pkg::FULL_TURN;
    end else begin
      delta = delta_raw;
    end
  end

  // take the short way around when the angle crosses zero
  always_comb begin
    priority if (last_s > rau_pkg::HALF_TURN && v_s < last_s - rau_pkg::HALF_TURN) begin
      step = rau_pkg::FULL_TURN - last_s + v_s;
    end else if (v_s > rau_pkg::HALF_TURN && last_s < v_s - rau_pkg::HALF_TURN) begin
      step = v_s - last_s - rau_pkg::FULL_TURN;
    end else begin
      step = v_s - last_s;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    good_angle_nxt = good_angle_r;
    sref_angle_nxt = sref_angle_r;
    sref_time_nxt  = sref_time_r;
    cum_pos_nxt    = cum_pos_r;
    uref_angle_nxt = uref_angle_r;
    res_angle_nxt  = res_angle_r;
    res_pos_nxt    = res_pos_r;
    res_speed_nxt  = res_speed_r;
    res_valid_nxt  = res_valid_r;
    mag_nxt        = mag_r;
    neg_nxt        = neg_r;
    elapsed_nxt    = elapsed_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        res_speed_nxt = '0;
        res_valid_nxt = 1'b0;
        state_nxt     = ST_DONE;
        if (act_r) begin
          // preset: rebase unwrap, report the old position
          if (!err_r) begin
            good_angle_nxt = corr;
          end
          res_angle_nxt  = err_r ? good_angle_r : corr;
          uref_angle_nxt = err_r ? good_angle_r : corr;
          res_pos_nxt    = cum_pos_r;
          cum_pos_nxt    = preset_r;
        end else if (use_new_r && err_r) begin
          // failed read: hold everything
          res_angle_nxt = good_angle_r;
          res_pos_nxt   = cum_pos_r;
        end else begin
          good_angle_nxt = smp_angle;
          res_angle_nxt  = smp_angle;
          sref_time_nxt  = time_r;
          sref_angle_nxt = smp_angle;
          uref_angle_nxt = smp_angle;
          cum_pos_nxt    = cum_pos_r + {{(rau_pkg::POS_W-14){step[13]}}, step};
          res_pos_nxt    = cum_pos_r + {{(rau_pkg::POS_W-14){step[13]}}, step};
          neg_nxt        = delta[13];
          mag_nxt        = delta[13] ? rau_pkg::ANGLE_W'(-delta)
                                     : rau_pkg::ANGLE_W'(delta);
          elapsed_nxt    = elapsed_c;
          if (elapsed_c != '0) begin
            res_valid_nxt = 1'b1;
            state_nxt     = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          res_speed_nxt = neg_r ? (rau_pkg::POS_W'(0) - div_q) : div_q;
          state_nxt     = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      offset_r     <= '0;
      reverse_r    <= 1'b0;
      good_angle_r <= '0;
      sref_angle_r <= '0;
      sref_time_r  <= '0;
      cum_pos_r    <= '0;
      uref_angle_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      good_angle_r <= good_angle_nxt;
      sref_angle_r <= sref_angle_nxt;
      sref_time_r  <= sref_time_nxt;
      cum_pos_r    <= cum_pos_nxt;
      uref_angle_r <= uref_angle_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          rau_pkg::CFG_ANGLE_OFFSET: offset_r  <= cfg_wdata;
          rau_pkg::CFG_REVERSE:      reverse_r <= cfg_wdata[0];
          default:                   offset_r  <= offset_r;
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_r     <= in_action;
      raw_r     <= in_raw_angle;
      err_r     <= in_read_error;
      use_new_r <= in_use_new_reading;
      time_r    <= in_time_us;
      preset_r  <= in_preset_position;
    end
    res_angle_r <= res_angle_nxt;
    res_pos_r   <= res_pos_nxt;
    res_speed_r <= res_speed_nxt;
    res_valid_r <= res_valid_nxt;
    mag_r       <= mag_nxt;
    neg_r       <= neg_nxt;
    elapsed_r   <= elapsed_nxt;
    // |delta| <= 2048, so the scaled value stays within 32 bits
    if (state_r == ST_MUL) begin
      prod_r <= {{(rau_pkg::DIV_W-rau_pkg::ANGLE_W){1'b0}}, mag_r}
                * {{(rau_pkg::DIV_W-20){1'b0}}, rau_pkg::US_PER_S};
    end
    if (out_load) begin
      out_angle_r <= res_angle_r;
      out_pos_r   <= res_pos_r;
      out_rev_r   <= res_pos_r[rau_pkg::POS_W-1:12]
                     + {{(rau_pkg::REV_W-1){1'b0}}, res_pos_r[rau_pkg::POS_W-1]};
      out_speed_r <= res_speed_r;
      out_sv_r    <= res_valid_r;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_angle              = out_angle_r;
  assign out_position           = $signed(out_pos_r);
  assign out_revolutions        = $signed(out_rev_r);
  assign out_speed_counts_per_s = $signed(out_speed_r);
  assign out_speed_valid        = out_sv_r;

`ifndef SYNTHESIS
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> state_r == ST_DIV)
    else $error("divider finished outside the divide phase");

  a_accept_to_calc: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == ST_CALC)
    else $error("accepted beat did not start processing");

  a_invalid_speed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_sv_r |-> out_speed_r == '0)
    else $error("speed nonzero while flagged invalid");

  a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r && state_r == ST_IDLE)
    else $error("finished item did not reach the output register");

  a_div_idle_outside: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE || state_r == ST_DONE) |-> !div_stat.busy)
    else $error("divider busy with no item in flight");
`endif

endmodule

>>> verif/tb_rotary_angle_unwrap_tracker.sv
`timescale 1ns / 1ps
// Testbench for rotary_angle_unwrap_tracker: directed and random sample beats under
// several offset/direction settings, checked field by field against a behavioral tracker.
// Depends on rau_pkg and the tracker RTL.
module tb_rotary_angle_unwrap_tracker;
  import rau_pkg::*;

  typedef enum logic {
    ACT_SAMPLE = 1'b0,
    ACT_PRESET = 1'b1
  } action_e;

  typedef struct {
    action_e            action;
    logic [ANGLE_W-1:0] raw;
    logic               err;
    logic               use_new;
    logic [TIME_W-1:0]  t_us;
    logic [POS_W-1:0]   preset;
  } sample_t;

  typedef struct {
    logic [ANGLE_W-1:0] angle;
    logic [POS_W-1:0]   position;
    logic [REV_W-1:0]   revs;
    logic [POS_W-1:0]   speed;
    logic               speed_ok;
  } track_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_we = 1'b0;
  logic                      cfg_addr = CFG_ANGLE_OFFSET;
  logic [ANGLE_W-1:0]        cfg_wdata = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      in_action = ACT_SAMPLE;
  logic [ANGLE_W-1:0]        in_raw_angle = '0;
  logic                      in_read_error = 1'b0;
  logic                      in_use_new_reading = 1'b0;
  logic [TIME_W-1:0]         in_time_us = '0;
  logic signed [POS_W-1:0]   in_preset_position = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [ANGLE_W-1:0]        out_angle;
  logic signed [POS_W-1:0]   out_position;
  logic signed [REV_W-1:0]   out_revolutions;
  logic signed [POS_W-1:0]   out_speed_counts_per_s;
  logic                      out_speed_valid;

  // tracker model state and its copy of the registers
  logic [ANGLE_W-1:0] trk_offset = '0;
  logic               trk_reverse = 1'b0;
  logic [ANGLE_W-1:0] good_angle = '0;
  logic [ANGLE_W-1:0] spd_ref_angle = '0;
  logic [TIME_W-1:0]  spd_ref_time = '0;
  logic [POS_W-1:0]   cum_pos = '0;
  logic [ANGLE_W-1:0] unwrap_angle = '0;

  sample_t sample_q[$];
  track_t  track_results_q[$];
  sample_t held_beat;
  bit      beat_held = 1'b0;
  int      send_wait = 0;
  int      stall_left = 0;
  int      send_gap_max = 4;
  int      recv_gap_max = 4;
  int      err_cnt = 0;

  // random walk of the stimulus
  logic [ANGLE_W-1:0] walk_raw = '0;
  logic [TIME_W-1:0]  walk_time = '0;

  rotary_angle_unwrap_tracker u_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_addr               (cfg_addr),
    .cfg_wdata              (cfg_wdata),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_action              (in_action),
    .in_raw_angle           (in_raw_angle),
    .in_read_error          (in_read_error),
    .in_use_new_reading     (in_use_new_reading),
    .in_time_us             (in_time_us),
    .in_preset_position     (in_preset_position),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_angle              (out_angle),
    .out_position           (out_position),
    .out_revolutions        (out_revolutions),
    .out_speed_counts_per_s (out_speed_counts_per_s),
    .out_speed_valid        (out_speed_valid)
  );

  always #6 clk = ~clk;

  function automatic logic [ANGLE_W-1:0] offset_mirror(logic [ANGLE_W-1:0] raw);
    logic [ANGLE_W-1:0] a;
    a = raw + trk_offset;
    if (trk_reverse) begin
      a = ~a + 1'b1;
    end
    return a;
  endfunction

  // floor(pos / 4096), plus one for negative positions
  function automatic logic [REV_W-1:0] revs_from_pos(logic [POS_W-1:0] pos);
    logic signed [POS_W-1:0] q;
    q = $signed(pos) >>> ANGLE_W;
    if (pos[POS_W-1]) begin
      q = q + 1;
    end
    return q[REV_W-1:0];
  endfunction

  function automatic track_t track_step(sample_t s);
    track_t                r;
    int                    d;
    int                    v;
    int                    last;
    int                    stp;
    logic [TIME_W-1:0]     elapsed;
    longint unsigned       mag;
    longint unsigned       q;
    r.speed = '0;
    r.speed_ok = 1'b0;
    if (s.action == ACT_PRESET) begin
      if (!s.err) begin
        good_angle = offset_mirror(s.raw);
      end
      r.angle = good_angle;
      unwrap_angle = good_angle;
      r.position = cum_pos;
      cum_pos = s.preset;
    end else if (s.use_new && s.err) begin
      r.angle = good_angle;
      r.position = cum_pos;
    end else begin
      if (s.use_new) begin
        good_angle = offset_mirror(s.raw);
      end
      r.angle = good_angle;
      elapsed = s.t_us - spd_ref_time;
      d = int'(good_angle) - int'(spd_ref_angle);
      if (d > int'(HALF_TURN)) begin
        d = d - int'(FULL_TURN);
      end else if (d < -int'(HALF_TURN)) begin
        d = d + int'(FULL_TURN);
      end
      if (elapsed != 0) begin
        mag = longint'((d < 0) ? -d : d);
        q = (mag * longint'(US_PER_S)) / longint'(elapsed);
        r.speed = (d < 0) ? (32'd0 - q[31:0]) : q[31:0];
        r.speed_ok = 1'b1;
      end
      spd_ref_time = s.t_us;
      spd_ref_angle = good_angle;
      // take the short way around the circle
      v = int'(good_angle);
      last = int'(unwrap_angle);
      if (last > int'(HALF_TURN) && v < last - int'(HALF_TURN)) begin
        stp = int'(FULL_TURN) - last + v;
      end else if (v > int'(HALF_TURN) && last < v - int'(HALF_TURN)) begin
        stp = -int'(FULL_TURN) - last + v;
      end else begin
        stp = v - last;
      end
      cum_pos = cum_pos + 32'(stp);
      unwrap_angle = good_angle;
      r.position = cum_pos;
    end
    r.revs = revs_from_pos(r.position);
    return r;
  endfunction

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      beat_held = 1'b0;
      send_wait = 0;
    end else begin
      if (in_valid && !in_stall) begin
        track_results_q.push_back(track_step(held_beat));
        beat_held = 1'b0;
      end
      if (!beat_held) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (sample_q.size() != 0) begin
          held_beat = sample_q.pop_front();
          in_action <= held_beat.action;
          in_raw_angle <= held_beat.raw;
          in_read_error <= held_beat.err;
          in_use_new_reading <= held_beat.use_new;
          in_time_us <= held_beat.t_us;
          in_preset_position <= held_beat.preset;
          in_valid <= 1'b1;
          beat_held = 1'b1;
          send_wait = $urandom_range(0, send_gap_max);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    track_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (track_results_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("unexpected result beat: angle %0d pos %0d rev %0d speed %0d ok %0b",
                     out_angle, out_position, out_revolutions, out_speed_counts_per_s,
                     out_speed_valid);
          end
        end else begin
          want = track_results_q.pop_front();
          if (out_angle !== want.angle || out_position !== want.position ||
              out_revolutions !== want.revs || out_speed_counts_per_s !== want.speed ||
              out_speed_valid !== want.speed_ok) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("mismatch exp: angle %0d pos %0d rev %0d speed %0d ok %0b",
                       want.angle, $signed(want.position), $signed(want.revs),
                       $signed(want.speed), want.speed_ok);
              $display("         got: angle %0d pos %0d rev %0d speed %0d ok %0b",
                       out_angle, out_position, out_revolutions, out_speed_counts_per_s,
                       out_speed_valid);
            end
          end
        end
        stall_left = $urandom_range(0, recv_gap_max);
      end else if (out_valid && stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left > 0);
    end
  end

  task automatic add_sample(action_e act, logic [ANGLE_W-1:0] raw, logic err, logic use_new,
                            logic [TIME_W-1:0] t_us, logic [POS_W-1:0] preset);
    sample_t s;
    s.action = act;
    s.raw = raw;
    s.err = err;
    s.use_new = use_new;
    s.t_us = t_us;
    s.preset = preset;
    sample_q.push_back(s);
  endtask

  function automatic sample_t rand_sample();
    sample_t s;
    s.action = ($urandom_range(0, 99) < 6) ? ACT_PRESET : ACT_SAMPLE;
    s.err = ($urandom_range(0, 9) == 0);
    s.use_new = ($urandom_range(0, 7) != 0);
    case ($urandom_range(0, 9))
      0: walk_raw = 12'($urandom_range(0, 4095));
      1: walk_raw = walk_raw + 12'($urandom_range(2040, 2056));
      default: walk_raw = walk_raw + 12'($urandom_range(0, 400)) - 12'd200;
    endcase
    s.raw = walk_raw;
    case ($urandom_range(0, 19))
      0: walk_time = walk_time;
      1: walk_time = $urandom();
      2: walk_time = walk_time + 1;
      default: walk_time = walk_time + $urandom_range(1, 20000);
    endcase
    s.t_us = walk_time;
    case ($urandom_range(0, 3))
      0: s.preset = 32'h7FFF_FFFF - $urandom_range(0, 3000);
      1: s.preset = 32'h8000_0000 + $urandom_range(0, 3000);
      default: s.preset = $urandom();
    endcase
    return s;
  endfunction

  task automatic write_reg(logic idx, logic [ANGLE_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_ANGLE_OFFSET) begin
      trk_offset = val;
    end else begin
      trk_reverse = val[0];
    end
  endtask

  // hold off until every queued beat is sent and every result is back
  task automatic drain();
    do begin
      @(posedge clk);
    end while (sample_q.size() != 0 || beat_held || track_results_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    logic [ANGLE_W-1:0] offs[6];
    logic               revs[6];
    offs = '{12'hFFF, 12'h000, 12'hFFF, 12'h000, 12'h001, 12'h000};
    revs = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1};
    offs[3] = 12'($urandom_range(0, 4095));
    offs[5] = 12'($urandom_range(0, 4095));
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    write_reg(CFG_ANGLE_OFFSET, 12'h000);
    write_reg(CFG_REVERSE, 1'b0);
    add_sample(ACT_SAMPLE, 12'd0, 1'b0, 1'b1, 32'd0, 32'd0);            // zero elapsed time
    add_sample(ACT_SAMPLE, 12'd4095, 1'b0, 1'b1, 32'd1000, 32'd0);      // back across zero
    add_sample(ACT_SAMPLE, 12'd2048, 1'b0, 1'b1, 32'd1001, 32'd0);
    add_sample(ACT_SAMPLE, 12'd0, 1'b0, 1'b1, 32'd1002, 32'd0);         // exactly minus half turn
    add_sample(ACT_SAMPLE, 12'd2048, 1'b0, 1'b1, 32'd1003, 32'd0);      // exactly plus half turn
    add_sample(ACT_SAMPLE, 12'd100, 1'b1, 1'b1, 32'd2000, 32'hFFFF_FFFF); // failed read
    add_sample(ACT_SAMPLE, 12'd4095, 1'b1, 1'b0, 32'd2000, 32'd0);      // reuse, error ignored
    add_sample(ACT_PRESET, 12'd100, 1'b0, 1'b1, 32'd2100, 32'h7FFF_FFFF);
    add_sample(ACT_SAMPLE, 12'd300, 1'b0, 1'b1, 32'd2200, 32'd0);       // position overflow
    add_sample(ACT_PRESET, 12'd4095, 1'b1, 1'b0, 32'd2300, 32'h8000_0000); // preset, bad read
    add_sample(ACT_SAMPLE, 12'd4095, 1'b0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_sample(ACT_SAMPLE, 12'd2047, 1'b0, 1'b1, 32'd0, 32'd0);         // timestamp wraps
    add_sample(ACT_SAMPLE, 12'd4095, 1'b0, 1'b1, 32'd1, 32'd0);         // top speed
    add_sample(ACT_PRESET, 12'd0, 1'b0, 1'b1, 32'd2, 32'hFFFF_FFFF);
    add_sample(ACT_SAMPLE, 12'd1, 1'b0, 1'b1, 32'd1, 32'd0);            // zero elapsed time again
    add_sample(ACT_PRESET, 12'hABC, 1'b0, 1'b0, 32'd5, 32'hFFFF_F000);
    add_sample(ACT_SAMPLE, 12'd5, 1'b0, 1'b0, 32'd9, 32'd0);
    add_sample(ACT_SAMPLE, 12'h555, 1'b0, 1'b1, 32'h5555_5555, 32'h5555_5555);
    add_sample(ACT_SAMPLE, 12'hAAA, 1'b0, 1'b1, 32'hAAAA_AAAA, 32'hAAAA_AAAA);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_ANGLE_OFFSET, offs[ph]);
      write_reg(CFG_REVERSE, revs[ph]);
      // one phase runs back to back on both sides
      send_gap_max = (ph == 2) ? 0 : 4;
      recv_gap_max = (ph == 2) ? 0 : 4;
      for (int i = 0; i < 230; i++) begin
        sample_q.push_back(rand_sample());
      end
      drain();
    end

    repeat (40) @(posedge clk);
    if (err_cnt == 0 && track_results_q.size() == 0) begin
      $display("tb_rotary_angle_unwrap_tracker: PASS");
    end else begin
      $display("tb_rotary_angle_unwrap_tracker: FAIL");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("tb_rotary_angle_unwrap_tracker: FAIL");
    $finish;
  end

endmodule
